[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file lpd_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define LPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lpd_pkg.sv]
package lpd_pkg;

  localparam int ByteW       = 8;
  localparam int CountW      = 32;
  localparam int LenW        = 32;
  localparam int KindW       = 3;
  localparam int PrefixBytes = 4;
  localparam logic [LenW-1:0] MaxLenReset = '1;

  typedef enum logic [KindW-1:0] {
    KIND_BODY       = 3'd0,
    KIND_EMPTY      = 3'd1,
    KIND_CLEAN_END  = 3'd2,
    KIND_TOO_LONG   = 3'd3,
    KIND_EOF_PREFIX = 3'd4,
    KIND_EOF_BODY   = 3'd5
  } kind_t;

  // One input item as it leaves the skid buffer.
  typedef struct packed {
    logic             eos;
    logic [ByteW-1:0] data;
  } item_t;

endpackage

[hw/rtl/length_prefix_deframer.sv]
// Length-prefixed frame splitter for a byte stream.
// The input channel carries one transfer per stream byte; tuser high marks the
// end of the stream instead of a byte. Each frame is a big-endian length prefix
// of PREFIX_BYTES bytes followed by that many body bytes. Body bytes come out
// one per transfer with tlast on the final one; an empty frame, a clean end,
// a too-long prefix and an end inside a prefix or body each give one transfer
// whose kind is in out_tuser. Every result also carries the running frame,
// byte and prefix-byte counts. Only the last prefix byte can give a result (empty
// frame or too-long prefix). Each input transfer is held in the skid register;
// its result is then computed and registered. One input transfer is taken per
// cycle unless the receiver stalls. The user must write the maximum body length
// through cfg_wen/cfg_wdata only while idle; the block does not enforce it. Reset
// (synchronous, active low) empties both registers, clears all counters and sets
// the maximum length to all ones. When the receiver stalls, the result register
// holds and the skid buffer absorbs one more byte before in_tready drops.
module length_prefix_deframer #(
  parameter int PREFIX_BYTES = lpd_pkg::PrefixBytes
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wen,
  input  logic [lpd_pkg::LenW-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] stream_byte
  input  logic                     in_tuser,   // [0] end_of_stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [7:0] body_byte, [39:8] frames_total, [71:40] bytes_total,
  // [103:72] header_bytes_total
  output logic [103:0]             out_tdata,
  output logic [2:0]               out_tuser,  // [2:0] result_kind
  output logic                     out_tlast   // frame_last
);

  lpd_pkg::item_t             in_item, item;
  logic                       item_valid, item_take;
  lpd_pkg::kind_t             out_kind;
  logic [lpd_pkg::ByteW-1:0]  out_byte;
  logic [lpd_pkg::CountW-1:0] out_frames, out_bytes, out_hdr_bytes;

  assign in_item.eos  = in_tuser;
  assign in_item.data = in_tdata;

  lpd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  lpd_core #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (out_kind),
    .out_last      (out_tlast),
    .out_byte      (out_byte),
    .out_frames    (out_frames),
    .out_bytes     (out_bytes),
    .out_hdr_bytes (out_hdr_bytes)
  );

  assign out_tdata = {out_hdr_bytes, out_bytes, out_frames, out_byte};
  assign out_tuser = out_kind;

endmodule

[hw/rtl/lpd_skid.sv]
module lpd_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lpd_pkg::item_t in_item,
  output logic          item_valid,
  input  logic          item_take,
  output lpd_pkg::item_t item
);

  logic           main_valid_r, main_valid_nxt;
  logic           spare_valid_r, spare_valid_nxt;
  lpd_pkg::item_t main_r, main_nxt;
  lpd_pkg::item_t spare_r, spare_nxt;
  logic           push, pop;

  // Ready comes straight from a register, so the sender never sees the
  // downstream stall combinationally.
  assign in_tready  = !spare_valid_r;
  assign push       = in_tvalid && in_tready;
  assign pop        = main_valid_r && item_take;
  assign item_valid = main_valid_r;
  assign item       = main_r;

  always_comb begin
    main_valid_nxt  = main_valid_r;
    spare_valid_nxt = spare_valid_r;
    main_nxt        = main_r;
    spare_nxt       = spare_r;
    if (pop) begin
      if (spare_valid_r) begin
        main_nxt        = spare_r;
        spare_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = in_item;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = in_item;
      end else begin
        spare_valid_nxt = 1'b1;
        spare_nxt       = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      main_valid_r  <= main_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
    main_r  <= main_nxt;
    spare_r <= spare_nxt;
  end

endmodule

[hw/rtl/lpd_core.sv]
module lpd_core #(
  parameter int PREFIX_BYTES = lpd_pkg::PrefixBytes
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wen,
  input  logic [lpd_pkg::LenW-1:0]     cfg_wdata,
  input  logic                         item_valid,
  output logic                         item_take,
  input  lpd_pkg::item_t               item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lpd_pkg::kind_t               out_kind,
  output logic                         out_last,
  output logic [lpd_pkg::ByteW-1:0]    out_byte,
  output logic [lpd_pkg::CountW-1:0]   out_frames,
  output logic [lpd_pkg::CountW-1:0]   out_bytes,
  output logic [lpd_pkg::CountW-1:0]   out_hdr_bytes
);

  localparam int PosW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam logic [PosW:0] PosLast = (PosW + 1)'(PREFIX_BYTES);

  logic [lpd_pkg::LenW-1:0]   max_len_r;
  logic                       in_body_r, in_body_nxt;
  logic [PosW-1:0]            pos_r, pos_nxt;
  logic [PosW:0]              pos_inc;
  logic [lpd_pkg::LenW-1:0]   len_r, len_nxt, len_shift;
  logic [lpd_pkg::LenW-1:0]   rem_r, rem_nxt;
  logic [lpd_pkg::CountW-1:0] frames_r, frames_nxt;
  logic [lpd_pkg::CountW-1:0] bytes_r, bytes_nxt;
  logic [lpd_pkg::CountW-1:0] hdr_r, hdr_nxt;
  logic                       emit;
  lpd_pkg::kind_t             kind;
  logic                       last;
  logic [lpd_pkg::ByteW-1:0]  body_byte;

  logic                       out_valid_r;
  lpd_pkg::kind_t             out_kind_r;
  logic                       out_last_r;
  logic [lpd_pkg::ByteW-1:0]  out_byte_r;
  logic [lpd_pkg::CountW-1:0] out_frames_r, out_bytes_r, out_hdr_r;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign pos_inc   = {1'b0, pos_r} + (PosW + 1)'(1);
  assign len_shift = {len_r[lpd_pkg::LenW-lpd_pkg::ByteW-1:0], item.data};

  always_comb begin
    in_body_nxt = in_body_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    frames_nxt  = frames_r;
    bytes_nxt   = bytes_r;
    hdr_nxt     = hdr_r;
    emit        = 1'b0;
    kind        = lpd_pkg::KIND_BODY;
    last        = 1'b0;
    body_byte   = '0;
    if (item.eos) begin
      emit = 1'b1;
      if (in_body_r) begin
        kind = lpd_pkg::KIND_EOF_BODY;
      end else if (pos_r != '0) begin
        kind = lpd_pkg::KIND_EOF_PREFIX;
      end else begin
        kind = lpd_pkg::KIND_CLEAN_END;
      end
      in_body_nxt = 1'b0;
      pos_nxt     = '0;
      len_nxt     = '0;
      rem_nxt     = '0;
    end else begin
      bytes_nxt = bytes_r + lpd_pkg::CountW'(1);
      if (in_body_r) begin
        emit      = 1'b1;
        body_byte = item.data;
        rem_nxt   = rem_r - lpd_pkg::LenW'(1);
        if (rem_r == lpd_pkg::LenW'(1)) begin
          last        = 1'b1;
          frames_nxt  = frames_r + lpd_pkg::CountW'(1);
          in_body_nxt = 1'b0;
          pos_nxt     = '0;
          len_nxt     = '0;
          rem_nxt     = '0;
        end
      end else if (pos_inc != PosLast) begin
        len_nxt = len_shift;
        pos_nxt = pos_inc[PosW-1:0];
      end else begin
        // Prefix complete: decide on the length just assembled.
        hdr_nxt = hdr_r + lpd_pkg::CountW'(PREFIX_BYTES);
        pos_nxt = '0;
        len_nxt = '0;
        rem_nxt = '0;
        if (len_shift > max_len_r) begin
          emit = 1'b1;
          kind = lpd_pkg::KIND_TOO_LONG;
        end else if (len_shift == '0) begin
          emit       = 1'b1;
          kind       = lpd_pkg::KIND_EMPTY;
          last       = 1'b1;
          frames_nxt = frames_r + lpd_pkg::CountW'(1);
        end else begin
          in_body_nxt = 1'b1;
          rem_nxt     = len_shift;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= lpd_pkg::MaxLenReset;
      in_body_r   <= 1'b0;
      pos_r       <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      frames_r    <= '0;
      bytes_r     <= '0;
      hdr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_len_r <= cfg_wdata;
      end
      if (item_take) begin
        in_body_r <= in_body_nxt;
        pos_r     <= pos_nxt;
        len_r     <= len_nxt;
        rem_r     <= rem_nxt;
        frames_r  <= frames_nxt;
        bytes_r   <= bytes_nxt;
        hdr_r     <= hdr_nxt;
      end
      if (item_take && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (item_take && emit) begin
      out_kind_r   <= kind;
      out_last_r   <= last;
      out_byte_r   <= body_byte;
      out_frames_r <= frames_nxt;
      out_bytes_r  <= bytes_nxt;
      out_hdr_r    <= hdr_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_last      = out_last_r;
  assign out_byte      = out_byte_r;
  assign out_frames    = out_frames_r;
  assign out_bytes     = out_bytes_r;
  assign out_hdr_bytes = out_hdr_r;

endmodule

[hw/rtl/lpd_checker.sv]
`include "assert_macros.svh"

module lpd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // A stalled result keeps its contents.
  `LPD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // Only a body byte or an empty frame closes a frame.
  `LPD_ASSERT(a_last_kind, out_tvalid && out_tlast |-> out_tuser == lpd_pkg::KIND_BODY || out_tuser == lpd_pkg::KIND_EMPTY, "tlast on a result that ends no frame")

  // The payload byte is zero on every result that is not a body byte.
  `LPD_ASSERT(a_byte_zero, out_tvalid && out_tuser != lpd_pkg::KIND_BODY |-> out_tdata[7:0] == 8'd0, "payload byte set on a non-body result")

  // Reset empties the result register by the next edge.
  `LPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
